// File: design/cld_pkg.sv
// Package for the class link dedup engine: sizes, action and status codes,
// the command that passes from the front to the back, and state types.
// Depends on nothing; every other design file imports it.
package cld_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_CLASSES  = 64;
   localparam int MAX_LINKS    = 256;

   localparam int ACTION_W = 2;
   localparam int VERTEX_W = 8;
   localparam int CLASS_W  = 6;
   localparam int STATUS_W = 3;
   localparam int VCOUNT_W = 9;

   localparam int SLOT_W     = $clog2(MAX_VERTICES);
   localparam int LINK_IDX_W = $clog2(MAX_LINKS);
   localparam int LINK_CNT_W = $clog2(MAX_LINKS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_W-1:0] ACT_ASSIGN = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_EDGE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ASSIGNED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SAME     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

   // What the back has to do with a classified item.
   typedef enum logic [2:0] {
      K_ASSIGNED,
      K_BAD,
      K_SAME,
      K_LINK,
      K_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [CLASS_W-1:0]   from_class;
      logic [CLASS_W-1:0]   to_class;
   } link_cmd_type;

   typedef enum logic {
      F_IDLE,
      F_CLASSIFY
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_SCAN
   } back_state_type;

endpackage

// File: design/class_link_dedup_engine.sv
// Assign, clear, same-class and bad items pass the front's item registers, the command queue
// and the registered result beat; an edge item that needs the store also waits for the store scan.
// The front takes no new item until the queue has taken the command of the last one; the back
// pops no command while it scans the store for an edge item, so later items wait in the queue.
// Reset (synchronous, active high) clears the valid bits, the link count and the queue at once;
// the receiver cannot stall, so every result beat is shown for exactly one cycle.
module class_link_dedup_engine
   import cld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [VERTEX_W-1:0]    req_source_vertex,
   input  logic [VERTEX_W-1:0]    req_dest_vertex,
   input  logic [CLASS_W-1:0]     req_class_id,
   output logic                   rsp_strobe,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_from_class,
   output logic [CLASS_W-1:0]     rsp_to_class,
   output logic [LINK_IDX_W-1:0]  rsp_link_index,
   output logic [LINK_CNT_W-1:0]  rsp_link_total,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [VCOUNT_W-1:0]    csr_vertex_count
);

   // The vertex count register. The user must send writes only while the engine is idle; the
   // block does not enforce it. The port is always ready; with that rule kept, no hazard against items exists.
   logic [VCOUNT_W-1:0] vertex_count_ff, vertex_count_in;

   // Handshake between the front and the queue, and the queue and the back.
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   link_cmd_type  push_cmd;
   link_cmd_type  head_cmd;

   assign csr_ready       = 1'b1;
   assign vertex_count_in = (csr_valid && csr_ready) ? csr_vertex_count : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // The front reads both endpoint classes on the accepting beat and
   // classifies the item in the next cycle, writing the class memory
   // for a valid assign item when it hands the command on.
   cld_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_action        (req_action),
      .req_source_vertex (req_source_vertex),
      .req_dest_vertex   (req_dest_vertex),
      .req_class_id      (req_class_id),
      .vertex_count      (vertex_count_ff),
      .q_full            (q_full),
      .busy              (busy),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // Commands leave the queue in order, so every result carries the link
   // total as it stands after all earlier items.
   cld_link_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   // The back scans the link store one entry a cycle with a registered
   // read, compares on the following cycle, and appends when no match
   // turns up and there is still room.
   cld_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (head_cmd),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_from_class (rsp_from_class),
      .rsp_to_class   (rsp_to_class),
      .rsp_link_index (rsp_link_index),
      .rsp_link_total (rsp_link_total)
   );

endmodule

// File: design/cld_front.sv
// Front of the class link dedup engine: accepts items, keeps the vertex
// class memory and valid bits, and classifies each item into a command.
// Depends on cld_pkg.
module cld_front
   import cld_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [VERTEX_W-1:0]  req_source_vertex,
   input  logic [VERTEX_W-1:0]  req_dest_vertex,
   input  logic [CLASS_W-1:0]   req_class_id,
   input  logic [VCOUNT_W-1:0]  vertex_count,
   input  logic                 q_full,
   output logic                 busy,
   output logic                 q_push,
   output link_cmd_type         q_cmd
);

   front_state_type state_ff, state_in;

   logic [ACTION_W-1:0]   item_action_ff;
   logic [VERTEX_W-1:0]   item_src_ff;
   logic [VERTEX_W-1:0]   item_dst_ff;
   logic [CLASS_W-1:0]    item_class_ff;
   logic [CLASS_W-1:0]    src_class_ff;
   logic [CLASS_W-1:0]    dst_class_ff;
   logic [MAX_VERTICES-1:0] assigned_ff;
   logic [CLASS_W-1:0]    class_mem [MAX_VERTICES];

   logic                  accept;
   logic                  class_wr;
   logic                  src_ok;
   logic                  dst_ok;
   logic                  class_ok;
   logic [SLOT_W-1:0]     src_slot;
   logic [SLOT_W-1:0]     dst_slot;
   logic [SLOT_W-1:0]     req_src_slot;
   logic [SLOT_W-1:0]     req_dst_slot;

   assign accept       = start && (state_ff == F_IDLE);
   assign busy         = (state_ff != F_IDLE);
   assign req_src_slot = SLOT_W'(req_source_vertex - VERTEX_W'(1));
   assign req_dst_slot = SLOT_W'(req_dest_vertex - VERTEX_W'(1));
   assign src_slot     = SLOT_W'(item_src_ff - VERTEX_W'(1));
   assign dst_slot     = SLOT_W'(item_dst_ff - VERTEX_W'(1));

   // An id up to 255 never exceeds the vertex store, so comparing against
   // the raw count is the same as comparing against the clamped count.
   assign src_ok   = (item_src_ff != '0) &&
                     ({1'b0, item_src_ff} <= vertex_count);
   assign dst_ok   = (item_dst_ff != '0) &&
                     ({1'b0, item_dst_ff} <= vertex_count);
   assign class_ok = ({1'b0, item_class_ff} < (CLASS_W + 1)'(MAX_CLASSES));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:     if (start) state_in = F_CLASSIFY;
         F_CLASSIFY: if (!q_full) state_in = F_IDLE;
         default:    state_in = F_IDLE;
      endcase
   end

   always_comb begin
      q_push         = (state_ff == F_CLASSIFY) && !q_full;
      class_wr       = 1'b0;
      q_cmd.kind       = K_BAD;
      q_cmd.from_class = '0;
      q_cmd.to_class   = '0;
      unique case (item_action_ff)
         ACT_ASSIGN: begin
            if (src_ok && class_ok) begin
               q_cmd.kind       = K_ASSIGNED;
               q_cmd.from_class = item_class_ff;
               class_wr         = q_push;
            end
         end
         ACT_EDGE: begin
            if (src_ok && dst_ok && assigned_ff[src_slot] && assigned_ff[dst_slot]) begin
               q_cmd.from_class = src_class_ff;
               q_cmd.to_class   = dst_class_ff;
               q_cmd.kind       = (src_class_ff == dst_class_ff) ? K_SAME : K_LINK;
            end
         end
         ACT_CLEAR: q_cmd.kind = K_CLEAR;
         default:   q_cmd.kind = K_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         assigned_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (class_wr) assigned_ff[src_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_action_ff <= req_action;
         item_src_ff    <= req_source_vertex;
         item_dst_ff    <= req_dest_vertex;
         item_class_ff  <= req_class_id;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_class_ff <= class_mem[req_src_slot];
         dst_class_ff <= class_mem[req_dst_slot];
      end
      if (class_wr) class_mem[src_slot] <= item_class_ff;
   end

endmodule

// File: design/cld_link_queue.sv
// Short command queue between the front and the back of the class link
// dedup engine, so that either side can stall on its own.
// Depends on cld_pkg.
module cld_link_queue
   import cld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  link_cmd_type  push_cmd,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output link_cmd_type  head_cmd
);

   link_cmd_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// File: design/cld_back.sv
// Back of the class link dedup engine: holds the link store, scans it for
// duplicates, appends new links and drives the registered result beat.
// Depends on cld_pkg.
module cld_back
   import cld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  link_cmd_type           q_cmd,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_from_class,
   output logic [CLASS_W-1:0]     rsp_to_class,
   output logic [LINK_IDX_W-1:0]  rsp_link_index,
   output logic [LINK_CNT_W-1:0]  rsp_link_total
);

   back_state_type state_ff, state_in;

   logic [LINK_CNT_W-1:0]        link_count_ff, link_count_in;
   logic [LINK_CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic [LINK_IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [2*CLASS_W-1:0]         rd_data_ff;
   logic [CLASS_W-1:0]           from_ff, from_in;
   logic [CLASS_W-1:0]           to_ff, to_in;
   logic [2*CLASS_W-1:0]         link_mem [MAX_LINKS];

   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [CLASS_W-1:0]           rsp_from_ff, rsp_from_in;
   logic [CLASS_W-1:0]           rsp_to_ff, rsp_to_in;
   logic [LINK_IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [LINK_CNT_W-1:0]        rsp_total_ff, rsp_total_in;

   logic                         rd_en;
   logic                         wr_en;
   logic                         match;
   logic                         more;
   logic                         store_full;

   assign match      = cmp_valid_ff && (rd_data_ff == {from_ff, to_ff});
   assign more       = (rd_idx_ff < link_count_ff);
   assign store_full = (link_count_ff >= LINK_CNT_W'(MAX_LINKS));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (q_valid && q_cmd.kind == K_LINK) state_in = B_SCAN;
         B_SCAN: if (match || (!more && !cmp_valid_ff)) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      link_count_in = link_count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_total_in  = rsp_total_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               from_in      = q_cmd.from_class;
               to_in        = q_cmd.to_class;
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               rsp_from_in  = q_cmd.from_class;
               rsp_to_in    = q_cmd.to_class;
               rsp_index_in = '0;
               rsp_total_in = link_count_ff;
               unique case (q_cmd.kind)
                  K_ASSIGNED: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_ASSIGNED;
                  end
                  K_SAME: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_SAME;
                  end
                  K_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_CLEARED;
                     link_count_in = '0;
                     rsp_total_in  = '0;
                  end
                  K_LINK: rsp_strobe_in = 1'b0;
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_BAD;
                  end
               endcase
            end
         end
         B_SCAN: begin
            rsp_from_in  = from_ff;
            rsp_to_in    = to_ff;
            rsp_total_in = link_count_ff;
            priority if (match) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_PRESENT;
               rsp_index_in  = cmp_idx_ff;
            end else if (more) begin
               rd_en        = 1'b1;
               rd_idx_in    = rd_idx_ff + LINK_CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[LINK_IDX_W-1:0];
            end else if (cmp_valid_ff) begin
               cmp_valid_in = 1'b0;
            end else if (store_full) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_index_in  = '0;
            end else begin
               wr_en         = 1'b1;
               link_count_in = link_count_ff + LINK_CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_ADDED;
               rsp_index_in  = link_count_ff[LINK_IDX_W-1:0];
               rsp_total_in  = link_count_ff + LINK_CNT_W'(1);
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         link_count_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         link_count_ff <= link_count_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      rsp_status_ff <= rsp_status_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= link_mem[rd_idx_ff[LINK_IDX_W-1:0]];
      if (wr_en) link_mem[link_count_ff[LINK_IDX_W-1:0]] <= {from_ff, to_ff};
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_from_class = rsp_from_ff;
   assign rsp_to_class   = rsp_to_ff;
   assign rsp_link_index = rsp_index_ff;
   assign rsp_link_total = rsp_total_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      link_count_ff <= LINK_CNT_W'(MAX_LINKS))
      else $error("link count beyond store size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SCAN) |-> (rd_idx_ff <= link_count_ff))
      else $error("scan index ran past the link count");

   a_added_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == ST_ADDED) |->
         (rsp_total_ff == {1'b0, rsp_index_ff} + LINK_CNT_W'(1)))
      else $error("added link index does not match new total");

   a_pop_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SCAN && rsp_strobe_in) |=> (state_ff == B_IDLE))
      else $error("scan continued after its result");

endmodule

// File: dv/class_link_dedup_engine_test.sv
// Self-checking testbench for class_link_dedup_engine: class assignment, link de-duplication,
// store clearing and store-full handling under random start gaps and vertex count settings.
// Depends on cld_pkg and the class_link_dedup_engine RTL only.
module class_link_dedup_engine_test
   import cld_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The package names three actions; the fourth encoding must be rejected by the block.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int GAP_LONGEST   = 19;
   localparam int SETTLE_CYCLES = 300;   // longer than a full store scan plus its overhead
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 170;

   // One command beat as it is presented on the req_ ports.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VERTEX_W-1:0] source_vertex;
      logic [VERTEX_W-1:0] dest_vertex;
      logic [CLASS_W-1:0]  class_id;
   } dedup_item_type;

   // One result beat as it appears on the rsp_ ports.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [CLASS_W-1:0]    from_class;
      logic [CLASS_W-1:0]    to_class;
      logic [LINK_IDX_W-1:0] link_index;
      logic [LINK_CNT_W-1:0] link_total;
   } link_result_type;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic [ACTION_W-1:0]   req_action        = '0;
   logic [VERTEX_W-1:0]   req_source_vertex = '0;
   logic [VERTEX_W-1:0]   req_dest_vertex   = '0;
   logic [CLASS_W-1:0]    req_class_id      = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [CLASS_W-1:0]    rsp_from_class;
   logic [CLASS_W-1:0]    rsp_to_class;
   logic [LINK_IDX_W-1:0] rsp_link_index;
   logic [LINK_CNT_W-1:0] rsp_link_total;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [VCOUNT_W-1:0]   csr_vertex_count  = '0;

   class_link_dedup_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_source_vertex (req_source_vertex),
      .req_dest_vertex   (req_dest_vertex),
      .req_class_id      (req_class_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_from_class    (rsp_from_class),
      .rsp_to_class      (rsp_to_class),
      .rsp_link_index    (rsp_link_index),
      .rsp_link_total    (rsp_link_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_vertex_count  (csr_vertex_count)
   );

   // 12 ns period: six low, six high.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow state of the engine. It is only ever touched by the monitor below, at the rising
   // edge that accepts a command or register beat, so it tracks the block beat for beat.
   // ---------------------------------------------------------------------------------------
   logic [CLASS_W-1:0]  class_of_vertex [MAX_VERTICES];
   bit                  vertex_known    [MAX_VERTICES];
   logic [CLASS_W-1:0]  stored_from     [MAX_LINKS];
   logic [CLASS_W-1:0]  stored_to       [MAX_LINKS];
   int unsigned         stored_links    = 0;
   logic [VCOUNT_W-1:0] vertex_limit    = '0;

   dedup_item_type  pending_items [$];  // commands still to be presented by the driver
   link_result_type due_results   [$];  // predicted result beats, oldest first
   int unsigned  queued_count   = 0;
   int unsigned  accepted_count = 0;
   int unsigned  mismatch_count = 0;
   logic         req_fire       = 1'b0; // the command beat was taken at the last rising edge
   int unsigned  gap_left       = 0;
   int unsigned  gap_ceiling    = GAP_LONGEST;
   dedup_item_type next_item;

   // A vertex id is usable when it lies between one and the vertex count, the count being
   // clamped to the size of the class table.
   function automatic bit vertex_in_range(logic [VERTEX_W-1:0] id);
      int unsigned ceiling;
      ceiling = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
      return (id != 0) && (id <= ceiling);
   endfunction

   // Works out the result beat of one accepted command and updates the shadow state.
   function automatic link_result_type resolve_link(dedup_item_type it);
      link_result_type r;
      int unsigned  s;
      int unsigned  d;
      int unsigned  k;
      bit           found;
      r     = '0;
      s     = it.source_vertex;
      d     = it.dest_vertex;
      found = 1'b0;
      r.status = ST_BAD;
      case (it.action)
         ACT_ASSIGN: begin
            if (vertex_in_range(it.source_vertex)) begin
               class_of_vertex[s-1] = it.class_id;
               vertex_known[s-1]    = 1'b1;
               r.status             = ST_ASSIGNED;
               r.from_class         = it.class_id;
            end
         end
         ACT_EDGE: begin
            // Both ends must be in range and must already carry a class; otherwise the
            // beat is rejected with both classes reported as zero.
            if (vertex_in_range(it.source_vertex) && vertex_in_range(it.dest_vertex)
                && vertex_known[s-1] && vertex_known[d-1]) begin
               r.from_class = class_of_vertex[s-1];
               r.to_class   = class_of_vertex[d-1];
               if (r.from_class == r.to_class) begin
                  r.status = ST_SAME;
               end else begin
                  // The duplicate search comes before the full check, so a known pair is
                  // still found when the store has no room left.
                  for (k = 0; k < stored_links; k++) begin
                     if (!found && stored_from[k] == r.from_class
                         && stored_to[k] == r.to_class) begin
                        found        = 1'b1;
                        r.status     = ST_PRESENT;
                        r.link_index = LINK_IDX_W'(k);
                     end
                  end
                  if (!found) begin
                     if (stored_links >= MAX_LINKS) begin
                        r.status = ST_FULL;
                     end else begin
                        stored_from[stored_links] = r.from_class;
                        stored_to[stored_links]   = r.to_class;
                        r.status                  = ST_ADDED;
                        r.link_index              = LINK_IDX_W'(stored_links);
                        stored_links++;
                     end
                  end
               end
            end
         end
         ACT_CLEAR: begin
            // Only the links go; vertex classes survive a clear.
            stored_links = 0;
            r.status     = ST_CLEARED;
         end
         default: begin
         end
      endcase
      r.link_total = LINK_CNT_W'(stored_links);
      return r;
   endfunction

   // Compares a result beat with the oldest prediction, field by field.
   task automatic check_result_beat();
      link_result_type got;
      link_result_type want;
      got = '{rsp_status, rsp_from_class, rsp_to_class, rsp_link_index, rsp_link_total};
      if (due_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result beat with nothing outstanding: %s %0d %0d %0d %0d %0d",
                     $time, "status/from/to/index/total", got.status, got.from_class,
                     got.to_class, got.link_index, got.link_total);
      end else begin
         want = due_results.pop_front();
         if (got.status !== want.status || got.from_class !== want.from_class
             || got.to_class !== want.to_class || got.link_index !== want.link_index
             || got.link_total !== want.link_total) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $write("%0t: expected status %0d from %0d to %0d index %0d total %0d, ",
                      $time, want.status, want.from_class, want.to_class, want.link_index,
                      want.link_total);
               $display("got status %0d from %0d to %0d index %0d total %0d",
                        got.status, got.from_class, got.to_class, got.link_index,
                        got.link_total);
            end
         end
      end
   endtask

   // Monitor: samples at the rising edge. A result beat is checked before the command beat
   // of the same edge is predicted; the two can never belong to the same command anyway.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_strobe)
            check_result_beat();
         if (csr_valid && csr_ready)
            vertex_limit = csr_vertex_count;
         if (start && !busy) begin
            due_results.push_back(resolve_link({req_action, req_source_vertex,
                                                req_dest_vertex, req_class_id}));
            accepted_count++;
         end
         req_fire <= start && !busy;
      end
   end

   // Gap before the next command. At least a quarter of the draws are zero so that back-to-back
   // beats occur even when gaps are allowed.
   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, gap_ceiling);
   endfunction

   // Driver: changes the inputs at the falling edge only. start is held until the block
   // takes the beat, then the drawn gap is served before the next command goes out.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_fire) begin
         // Still waiting for the block to take the current beat.
      end else if (gap_left != 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
         next_item         = pending_items.pop_front();
         req_action        <= next_item.action;
         req_source_vertex <= next_item.source_vertex;
         req_dest_vertex   <= next_item.dest_vertex;
         req_class_id      <= next_item.class_id;
         start             <= 1'b1;
         gap_left          <= draw_gap();
      end else begin
         start <= 1'b0;
      end
   end

   task automatic queue_item(logic [ACTION_W-1:0] action, int unsigned src, int unsigned dst,
                             int unsigned cls);
      pending_items.push_back({action, VERTEX_W'(src), VERTEX_W'(dst), CLASS_W'(cls)});
      queued_count++;
   endtask

   // Returns at a falling edge once every queued command has been taken and every predicted
   // result has come back, then lets the engine settle before anything else is done.
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (accepted_count != queued_count || due_results.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   // Register writes happen only with the engine drained.
   task automatic program_vertex_count(int unsigned value);
      wait_for_drain();
      csr_valid        <= 1'b1;
      csr_vertex_count <= VCOUNT_W'(value);
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly valid endpoints from a small pool, so that edges find assigned vertices and
   // repeat pairs; now and then any id at all.
   function automatic int unsigned pick_vertex(int unsigned pool);
      if (pool == 0 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(1, pool);
   endfunction

   task automatic queue_random_item(int unsigned pool, int unsigned span);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         queue_item(ACT_ASSIGN, pick_vertex(pool), $urandom_range(0, 255),
                    $urandom_range(0, span - 1));
      else if (roll < 85)
         queue_item(ACT_EDGE, pick_vertex(pool), pick_vertex(pool), $urandom_range(0, 63));
      else if (roll < 89)
         queue_item(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 63));
      else
         // Noise: any action with any payload, the unused encoding included.
         queue_item(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 63));
   endtask

   // Stimulus sequencer.
   initial begin
      int unsigned count_plan [8];
      int unsigned pool_plan  [4];
      int unsigned span_plan  [3];
      int unsigned count;
      int unsigned reach;
      int unsigned pool;
      int unsigned span;
      int unsigned a;
      int unsigned b;

      count_plan = '{511, 1, 0, 2, 300, 0, 256, 64};
      pool_plan  = '{4, 12, 40, 255};
      span_plan  = '{3, 8, 64};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats with the full vertex range.
      program_vertex_count(MAX_VERTICES);
      queue_item(ACT_ASSIGN, 0, 0, 5);         // vertex zero is never valid
      queue_item(ACT_ASSIGN, 1, 0, 0);
      queue_item(ACT_ASSIGN, 255, 255, 63);
      queue_item(ACT_EDGE, 1, 2, 0);           // destination has no class yet
      queue_item(ACT_EDGE, 1, 1, 0);           // same class at both ends
      queue_item(ACT_EDGE, 1, 255, 0);         // first link
      queue_item(ACT_EDGE, 1, 255, 0);         // the same pair again
      queue_item(ACT_EDGE, 255, 1, 0);         // reversed pair is a new link
      queue_item(ACT_EDGE, 0, 1, 0);
      queue_item(ACT_EDGE, 1, 0, 0);
      queue_item(ACT_UNUSED, 255, 255, 63);
      queue_item(ACT_ASSIGN, 2, 0, 0);
      queue_item(ACT_EDGE, 2, 255, 0);        // another vertex, but a pair already held
      queue_item(ACT_ASSIGN, 2, 0, 42);        // reassignment
      queue_item(ACT_EDGE, 2, 255, 0);
      queue_item(ACT_CLEAR, 0, 0, 0);
      queue_item(ACT_CLEAR, 255, 255, 63);     // clearing an empty store
      queue_item(ACT_EDGE, 255, 1, 0);
      queue_item(ACT_EDGE, 255, 2, 0);
      @(posedge clock);

      // Fill the store to the brim: vertex n carries class n-1, and each step k uses a
      // distinct ordered pair of different classes. The last two new pairs find no room.
      wait_for_drain();
      @(posedge clock);
      queue_item(ACT_CLEAR, 0, 0, 0);
      for (int unsigned v = 1; v <= MAX_CLASSES; v++)
         queue_item(ACT_ASSIGN, v, 0, v - 1);
      for (int unsigned k = 0; k < MAX_LINKS + 2; k++) begin
         a = k % MAX_CLASSES;
         b = (a + 1 + k / MAX_CLASSES) % MAX_CLASSES;
         queue_item(ACT_EDGE, a + 1, b + 1, 0);
      end
      queue_item(ACT_EDGE, 1, 2, 0);           // held at the first slot, store full
      a = (MAX_LINKS - 1) % MAX_CLASSES;
      b = (a + 1 + (MAX_LINKS - 1) / MAX_CLASSES) % MAX_CLASSES;
      queue_item(ACT_EDGE, a + 1, b + 1, 0);   // held at the last slot
      queue_item(ACT_EDGE, 5, 5, 0);
      queue_item(ACT_CLEAR, 0, 0, 0);

      // Random phases, each under its own vertex count, pool, class spread and gap ceiling.
      for (int p = 0; p < 8; p++) begin
         count = (p == 5) ? $urandom_range(3, 255) : count_plan[p];
         program_vertex_count(count);
         reach       = (count > 255) ? 255 : count;
         pool        = pool_plan[$urandom_range(0, 3)];
         pool        = (pool > reach) ? reach : pool;
         span        = span_plan[$urandom_range(0, 2)];
         gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : GAP_LONGEST;
         for (int n = 0; n < PHASE_ITEMS; n++)
            queue_random_item(pool, span);
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && due_results.size() == 0)
         $display("** class_link_dedup_engine: PASSED **");
      else
         $display("** class_link_dedup_engine: FAILED **");
      $finish;
   end

   // Watchdog: several times the slowest legal run, with every edge scanning a full store.
   initial begin
      #25_000_000;
      $display("** class_link_dedup_engine: FAILED **");
      $finish;
   end

endmodule

// File: class_link_dedup_engine.f
design/cld_pkg.sv
design/cld_front.sv
design/cld_link_queue.sv
design/cld_back.sv
design/class_link_dedup_engine.sv
dv/class_link_dedup_engine_test.sv
